>>> hdl/spd_pkg.sv
// Package: payload types, constants and field widths for the shortest-path block.
package spd_pkg;

   localparam int DefMaxNodes   = 64;
   localparam int DefMaxEdges   = 1024;
   localparam int DefWeightBits = 16;
   localparam int CostBits      = 30;
   localparam logic [CostBits-1:0] Unreachable = 30'd1000000000;
   localparam int NodeCountBits = 7;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [0:0] REG_NODE_COUNT = 1'd0;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [15:0] edge_weight;
      logic [5:0]  start_node;
   } req_type;

   typedef struct packed {
      logic [5:0]          node_id;
      logic [CostBits-1:0] path_cost;
      logic                last_node;
      logic                edges_dropped;
   } rsp_type;

endpackage

>>> hdl/spd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module spd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> hdl/shortest_path_dijkstra.sv
// Top level: graph edge store, binary heap and Dijkstra sequencer over RAMs.
//
// Usage: items arrive on req_* (valid/stall). func 0 adds an edge at the
// head of the adjacency list of edge_from, func 2 empties the graph, func 1
// runs a search from start_node and emits node_count beats on rsp_* (at
// least one, at most min(MAX_NODES, 64)), one per node in order,
// last_node set on the final beat. Other codes are dropped.
// An edge item steps through accept, head read and write back; a clear
// sweeps the MAX_NODES list heads. A run resets all distances, then for
// each heap pop reads the top and last entries, sifts down level by level
// and checks for a stale entry; for each edge it reads the edge, relaxes
// it and, for a push, sifts up level by level. Results then drain in order.
// Reset clears control state and starts a sweep of all MAX_NODES entries
// that empties the list heads and sets all distances unreachable; no item
// is taken during it (the csr port works throughout). When the receiver
// stalls, the output beat holds and the sequencer waits; no result is lost.
module shortest_path_dijkstra
   import spd_pkg::*;
#(
   parameter int MAX_NODES   = DefMaxNodes,
   parameter int MAX_EDGES   = DefMaxEdges,
   parameter int WEIGHT_BITS = DefWeightBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spd_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spd_pkg::rsp_type     rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [1:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import spd_pkg::*;

   localparam int NB = $clog2(MAX_NODES);
   localparam int EB = $clog2(MAX_EDGES);
   localparam int LB = EB + 1;                  // link: index+1, 0 = end
   localparam int HD = MAX_EDGES + 1;
   localparam int HB = $clog2(HD);
   localparam int HSB = $clog2(HD + 1);
   localparam int ETB = $clog2(MAX_EDGES + 1);
   localparam int EW = NB + WEIGHT_BITS + LB;
   localparam int HW = CostBits + NB;
   localparam int OutMax = (MAX_NODES < 64) ? MAX_NODES : 64;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_ADD_RD, S_ADD_WR, S_CLR, S_RST,
      S_POP_RD, S_POP_TOP, S_POP_LAST, S_DN_RDL, S_DN_RDR, S_DN_CMP,
      S_DN_SWP, S_CHK, S_EDGE_RD, S_EDGE_DST, S_EDGE_REL, S_PUSH,
      S_UP_RD, S_UP_CMP, S_UP_SWP, S_OUT_RD, S_OUT
   } state_type;

   state_type state_ff;
   logic [NodeCountBits-1:0] node_count_ff;
   logic                 overflow_ff;
   logic [ETB-1:0]       edge_total_ff;
   logic [HSB-1:0]       heap_size_ff;
   logic [NB:0]          sweep_ff;
   req_type              item_ff;
   logic [HB-1:0]        hi_ff, hc_ff;     // sift cursor and chosen child
   logic [HW-1:0]        hcur_ff, hbest_ff;
   logic [NB-1:0]        cur_ff;
   logic [CostBits-1:0]  dist_ff;
   logic [LB-1:0]        elink_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic [NB:0]          cnt_ff;

   // RAM ports
   logic            hd_we;   logic [NB-1:0] hd_wa, hd_ra; logic [LB-1:0] hd_wd, hd_rd;
   logic            es_we;   logic [EB-1:0] es_wa, es_ra; logic [EW-1:0] es_wd, es_rd;
   logic            ds_we;   logic [NB-1:0] ds_wa, ds_ra;
   logic [CostBits-1:0] ds_wd, ds_rd;
   logic            hp_we;   logic [HB-1:0] hp_wa, hp_ra; logic [HW-1:0] hp_wd, hp_rd;

   spd_ram #(.Width(LB), .Depth(MAX_NODES)) u_heads (.clock, .wr_en(hd_we),
      .wr_addr(hd_wa), .wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
   spd_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edges (.clock, .wr_en(es_we),
      .wr_addr(es_wa), .wr_data(es_wd), .rd_addr(es_ra), .rd_data(es_rd));
   spd_ram #(.Width(CostBits), .Depth(MAX_NODES)) u_dist (.clock, .wr_en(ds_we),
      .wr_addr(ds_wa), .wr_data(ds_wd), .rd_addr(ds_ra), .rd_data(ds_rd));
   spd_ram #(.Width(HW), .Depth(HD)) u_heap (.clock, .wr_en(hp_we),
      .wr_addr(hp_wa), .wr_data(hp_wd), .rd_addr(hp_ra), .rd_data(hp_rd));

   function automatic logic hless(input logic [HW-1:0] a, input logic [HW-1:0] b);
      hless = (a[HW-1:NB] != b[HW-1:NB]) ? (a[HW-1:NB] < b[HW-1:NB])
                                         : (a[NB-1:0] < b[NB-1:0]);
   endfunction

   // combinational helpers
   logic [HB:0]   lchild;
   logic [HB-1:0] parent;
   logic [HSB-1:0] hs_dec;
   logic [NB:0]   out_cnt;
   logic [CostBits+1:0] nd_sum;
   assign lchild = {hi_ff, 1'b1};
   assign parent = HB'((hi_ff - 1'b1) >> 1);
   assign hs_dec = heap_size_ff - 1'b1;
   assign nd_sum = {2'b0, dist_ff} + (CostBits+2)'(es_rd[NB +: WEIGHT_BITS]);

   always_comb begin
      out_cnt = (NB+1)'(node_count_ff);
      if (node_count_ff == '0) out_cnt = (NB+1)'(1);
      if ({{(32-NodeCountBits){1'b0}}, node_count_ff} > OutMax) out_cnt = (NB+1)'(OutMax);
   end

   // memory port drive
   always_comb begin
      hd_we = 1'b0; hd_wa = NB'(item_ff.edge_from); hd_wd = LB'(edge_total_ff + 1'b1);
      hd_ra = cur_ff;
      es_we = 1'b0; es_wa = edge_total_ff[EB-1:0];
      es_wd = {hd_rd, WEIGHT_BITS'(item_ff.edge_weight), NB'(item_ff.edge_to)};
      es_ra = EB'(elink_ff - 1'b1);
      ds_we = 1'b0; ds_wa = cur_ff; ds_wd = Unreachable; ds_ra = cur_ff;
      hp_we = 1'b0; hp_wa = hi_ff; hp_wd = hcur_ff; hp_ra = hi_ff;
      case (state_ff)
         S_INIT: begin
            hd_we = 1'b1; hd_wa = sweep_ff[NB-1:0]; hd_wd = '0;
            ds_we = 1'b1; ds_wa = sweep_ff[NB-1:0]; ds_wd = Unreachable;
         end
         S_ADD_RD:   hd_ra = NB'(item_ff.edge_from);
         S_ADD_WR: begin
            hd_we = 1'b1; es_we = 1'b1;
         end
         S_CLR: begin
            hd_we = 1'b1; hd_wa = sweep_ff[NB-1:0]; hd_wd = '0;
         end
         S_RST: begin
            ds_we = 1'b1; ds_wa = sweep_ff[NB-1:0];
            ds_wd = (sweep_ff[NB-1:0] == NB'(item_ff.start_node) &&
                     {{(NB+1){1'b0}}, item_ff.start_node} < (NB+7)'(MAX_NODES))
                    ? '0 : Unreachable;
         end
         S_POP_RD:   hp_ra = '0;
         S_POP_TOP:  hp_ra = HB'(heap_size_ff);
         S_POP_LAST: begin hp_we = 1'b1; hp_wa = '0; hp_wd = hp_rd; end
         // park the sifted entry at the cursor while its left child is read
         S_DN_RDL:   begin hp_we = 1'b1; hp_ra = lchild[HB-1:0]; end
         S_DN_RDR:   hp_ra = HB'(lchild + 1'b1);
         S_DN_SWP:   begin hp_we = 1'b1; hp_wa = hi_ff; hp_wd = hbest_ff; end
         S_CHK:      ds_ra = cur_ff;
         S_EDGE_DST: ds_ra = es_rd[NB-1:0];
         S_EDGE_REL: if (nd_sum < {2'b0, Unreachable} && nd_sum < {2'b0, ds_rd}) begin
            ds_we = 1'b1; ds_wa = es_rd[NB-1:0]; ds_wd = nd_sum[CostBits-1:0];
         end
         S_PUSH:     begin hp_we = 1'b1; hp_wa = hi_ff; end
         S_UP_RD:    hp_ra = parent;
         S_UP_SWP:   begin hp_we = 1'b1; hp_wa = hi_ff; hp_wd = hbest_ff; end
         S_OUT_RD:   ds_ra = cnt_ff[NB-1:0];
         default: ;
      endcase
   end

   logic req_acc;
   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == {REG_NODE_COUNT, 1'b0})
                       ? 32'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NodeCountBits'(64);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == {REG_NODE_COUNT, 1'b0}) begin
         node_count_ff <= csr_pwdata[NodeCountBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; sweep_ff <= '0; overflow_ff <= 1'b0;
         edge_total_ff <= '0; heap_size_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (NB+1)'(MAX_NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_acc) begin
               item_ff <= req_data;
               sweep_ff <= '0;
               case (req_data.func)
                  FUNC_ADD: if (32'(req_data.edge_from) < MAX_NODES &&
                                32'(req_data.edge_to) < MAX_NODES) begin
                     if (32'(edge_total_ff) >= MAX_EDGES) overflow_ff <= 1'b1;
                     else state_ff <= S_ADD_RD;
                  end
                  FUNC_CLEAR: begin
                     edge_total_ff <= '0; overflow_ff <= 1'b0; state_ff <= S_CLR;
                  end
                  FUNC_RUN: begin
                     heap_size_ff <= '0; state_ff <= S_RST;
                  end
                  default: ;
               endcase
            end
            S_ADD_RD: state_ff <= S_ADD_WR;
            S_ADD_WR: begin
               edge_total_ff <= edge_total_ff + 1'b1; state_ff <= S_IDLE;
            end
            S_CLR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (NB+1)'(MAX_NODES - 1)) state_ff <= S_IDLE;
            end
            S_RST: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (NB+1)'(MAX_NODES - 1)) begin
                  cnt_ff <= '0;
                  elink_ff <= '0;
                  if ({{(NB+1){1'b0}}, item_ff.start_node} < (NB+7)'(MAX_NODES)) begin
                     // seed the heap with the start node at distance zero
                     hi_ff <= '0; hcur_ff <= {{CostBits{1'b0}}, NB'(item_ff.start_node)};
                     heap_size_ff <= HSB'(1);
                     state_ff <= S_PUSH;
                  end else state_ff <= S_OUT_RD;
               end
            end
            S_PUSH: begin
               if (hi_ff != '0) state_ff <= S_UP_RD;
               else if (elink_ff != '0) state_ff <= S_EDGE_RD;
               else state_ff <= S_POP_RD;
            end
            S_UP_RD: state_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (hless(hcur_ff, hp_rd)) begin
                  hbest_ff <= hp_rd; state_ff <= S_UP_SWP;
               end else if (elink_ff != '0) state_ff <= S_EDGE_RD;
               else state_ff <= S_POP_RD;
            end
            S_UP_SWP: begin
               // parent moves down; continue with the pushed entry at parent
               hi_ff <= parent; state_ff <= S_PUSH;
            end
            S_POP_RD: begin
               if (heap_size_ff == '0) state_ff <= S_OUT_RD;
               else begin
                  heap_size_ff <= hs_dec; state_ff <= S_POP_TOP;
               end
            end
            S_POP_TOP: begin
               cur_ff <= hp_rd[NB-1:0]; dist_ff <= hp_rd[HW-1:NB];
               state_ff <= S_POP_LAST;
            end
            S_POP_LAST: begin
               hcur_ff <= hp_rd; hi_ff <= '0; state_ff <= S_DN_RDL;
            end
            S_DN_RDL: begin
               hbest_ff <= hcur_ff; hc_ff <= hi_ff;
               state_ff <= (32'(lchild) < 32'(heap_size_ff)) ? S_DN_RDR : S_CHK;
            end
            S_DN_RDR: begin
               if (hless(hp_rd, hbest_ff)) begin
                  hbest_ff <= hp_rd; hc_ff <= lchild[HB-1:0];
               end
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if ((32'(lchild) + 32'd1) < 32'(heap_size_ff) &&
                   hless(hp_rd, hbest_ff)) begin
                  hbest_ff <= hp_rd; hc_ff <= HB'(lchild + 1'b1);
                  state_ff <= S_DN_SWP;
               end else if (hc_ff != hi_ff) state_ff <= S_DN_SWP;
               else state_ff <= S_CHK;
            end
            S_DN_SWP: begin
               // child moves up; sifted entry goes on at the child's slot
               hi_ff <= hc_ff; state_ff <= S_DN_RDL;
            end
            S_CHK: begin
               // drop a stale entry, else fetch the node's first edge
               if (ds_rd < dist_ff) elink_ff <= '0;
               else elink_ff <= hd_rd;
               state_ff <= S_EDGE_RD;
            end
            S_EDGE_RD: begin
               if (elink_ff == '0) state_ff <= S_POP_RD;
               else state_ff <= S_EDGE_DST;
            end
            S_EDGE_DST: begin
               elink_ff <= es_rd[EW-1:NB+WEIGHT_BITS];
               state_ff <= S_EDGE_REL;
            end
            S_EDGE_REL: begin
               if (nd_sum < {2'b0, Unreachable} && nd_sum < {2'b0, ds_rd}) begin
                  hi_ff <= HB'(heap_size_ff);
                  hcur_ff <= {nd_sum[CostBits-1:0], es_rd[NB-1:0]};
                  heap_size_ff <= heap_size_ff + 1'b1;
                  state_ff <= S_PUSH;
               end else state_ff <= (elink_ff != '0) ? S_EDGE_RD : S_POP_RD;
            end
            S_OUT_RD: if (!rsp_valid_ff || !rsp_stall) state_ff <= S_OUT;
            S_OUT: if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ff.node_id <= 6'(cnt_ff);
               rsp_ff.path_cost <= ds_rd;
               rsp_ff.last_node <= (cnt_ff + 1'b1 == out_cnt);
               rsp_ff.edges_dropped <= overflow_ff;
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff + 1'b1 == out_cnt) ? S_IDLE : S_OUT_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held beat changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff != S_IDLE || rsp_data.last_node)
      else $error("beat pending while idle without last");
   assert property (@(posedge clock) disable iff (reset)
      32'(heap_size_ff) <= HD)
      else $error("heap overrun");
endmodule
